FILE: sv/arm_data_processing_alu_unit_assert.svh
// Assertion helpers for the data-processing execute unit.
// Both macros expect a clock named clk and an active-high reset named rst.
`ifndef ARM_DATA_PROCESSING_ALU_UNIT_ASSERT_SVH
`define ARM_DATA_PROCESSING_ALU_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARMDP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARMDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/armdp_pkg.sv
`default_nettype none

package armdp_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned RegCount  = 16;
  localparam int unsigned RegAddrW  = 4;

  // Status word layout when index 16 is read as an operand.
  localparam int unsigned BitN = 31;
  localparam int unsigned BitZ = 30;
  localparam int unsigned BitC = 29;
  localparam logic [4:0]  StatusIndex = 5'd16;

  // Opcodes.
  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;

  // Shift kinds of the register form of operand 2.
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  typedef struct packed {
    logic        immediate_form;
    logic [3:0]  opcode;
    logic        set_flags;
    logic [4:0]  first_register;
    logic [3:0]  dest_register;
    logic [11:0] operand_two;
  } instr_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
  } flags_t;

endpackage

`default_nettype wire

FILE: sv/arm_data_processing_alu_unit.sv
// Data-processing execute unit: the register file is read at the accepting edge into
// stage 1, where shift, ALU and writeback run; the result is registered on m_tdata when
// stage 1 commits, once the output register is empty or drained. Throughput is one
// instruction per cycle while m_tready is high, with a two-read, one-write register file.
// Reset (rst, synchronous, active high) clears the pipeline valids, the N, Z and C flags
// and the per-register valid bits, so every register reads as zero until written.
`default_nettype none

`include "arm_data_processing_alu_unit_assert.svh"

module arm_data_processing_alu_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Instruction requests.
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // s_tdata, from bit 0 up: opcode[3:0], set_flags[4], first_register[9:5],
  // dest_register[13:10], operand_two[25:14], zero fill [31:26].
  input  wire logic [31:0] s_tdata,
  // s_tuser: immediate_form[0].
  input  wire logic [0:0]  s_tuser,
  // Results.
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // m_tdata, from bit 0 up: result_value[31:0], written_register[35:32],
  // register_written[36], flag_negative[37], flag_zero[38], flag_carry[39].
  output      logic [39:0] m_tdata
);

  // ---------------------------------------------------------------------------------
  // Handshake and pipeline control.
  // Stage 1 holds the instruction whose register operands are being read out of the
  // memory. It commits (writes the register file, updates the flags and loads the
  // output register) when the output register is empty or is being drained.
  // ---------------------------------------------------------------------------------
  armdp_pkg::instr_t in_instr;
  armdp_pkg::instr_t s1_instr;
  logic              s1_valid;
  logic              s1_advance;
  logic              s_accept;

  assign in_instr.immediate_form = s_tuser[0];
  assign in_instr.opcode         = s_tdata[3:0];
  assign in_instr.set_flags      = s_tdata[4];
  assign in_instr.first_register = s_tdata[9:5];
  assign in_instr.dest_register  = s_tdata[13:10];
  assign in_instr.operand_two    = s_tdata[25:14];

  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign s_accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_instr <= in_instr;
    end
  end

  // ---------------------------------------------------------------------------------
  // Register file: 16 words with two synchronous read ports (first operand and shifted
  // register) and one write port. A valid bit per entry makes an entry that was never
  // written since reset read as zero. The read that happens at the same edge as the
  // write of the previous instruction takes the written value, so back-to-back
  // dependent instructions see their predecessor's result.
  // ---------------------------------------------------------------------------------
  logic [armdp_pkg::DataWidth-1:0] reg_mem [armdp_pkg::RegCount];
  logic [armdp_pkg::RegCount-1:0]  reg_valid;
  logic [armdp_pkg::DataWidth-1:0] rn_rdata;
  logic [armdp_pkg::DataWidth-1:0] rm_rdata;
  logic                            mem_we;
  logic [armdp_pkg::RegAddrW-1:0]  mem_waddr;
  logic [armdp_pkg::DataWidth-1:0] mem_wdata;
  logic [armdp_pkg::RegAddrW-1:0]  rn_raddr;
  logic [armdp_pkg::RegAddrW-1:0]  rm_raddr;

  assign rn_raddr = in_instr.first_register[armdp_pkg::RegAddrW-1:0];
  assign rm_raddr = in_instr.operand_two[3:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      reg_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
    end else if (mem_we) begin
      reg_valid[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      if (mem_we && (mem_waddr == rn_raddr)) begin
        rn_rdata <= mem_wdata;
      end else if (reg_valid[rn_raddr]) begin
        rn_rdata <= reg_mem[rn_raddr];
      end else begin
        rn_rdata <= '0;
      end
      if (mem_we && (mem_waddr == rm_raddr)) begin
        rm_rdata <= mem_wdata;
      end else if (reg_valid[rm_raddr]) begin
        rm_rdata <= reg_mem[rm_raddr];
      end else begin
        rm_rdata <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Status flags live in flip-flops; stage 1 reads them directly, so a flag update by
  // the committing instruction is seen by the next one without forwarding.
  // ---------------------------------------------------------------------------------
  armdp_pkg::flags_t flags;
  armdp_pkg::flags_t flags_next;

  // First operand: a general register, the status word for index 16, zero above that.
  logic [armdp_pkg::DataWidth-1:0] rn_val;
  logic [armdp_pkg::DataWidth-1:0] status_word;

  always_comb begin
    status_word = '0;
    status_word[armdp_pkg::BitN] = flags.n;
    status_word[armdp_pkg::BitZ] = flags.z;
    status_word[armdp_pkg::BitC] = flags.c;
  end

  always_comb begin
    if (!s1_instr.first_register[4]) begin
      rn_val = rn_rdata;
    end else if (s1_instr.first_register == armdp_pkg::StatusIndex) begin
      rn_val = status_word;
    end else begin
      rn_val = '0;
    end
  end

  // ---------------------------------------------------------------------------------
  // Barrel shifter. The immediate form rotates an 8-bit value right by twice the rotate
  // field and keeps the current carry. The register form shifts by a 5-bit constant;
  // a shift by zero passes the register through with the current carry, and the
  // register-specified shift form yields zero.
  // ---------------------------------------------------------------------------------
  logic [7:0]  imm8;
  logic [4:0]  imm_rot;
  logic [63:0] imm_dbl;
  logic [63:0] rm_dbl;
  logic [4:0]  sh_amount;
  logic [1:0]  sh_kind;
  logic [4:0]  lsl_bit;
  logic [4:0]  rsh_bit;
  logic [31:0] op2_val;
  logic        shift_carry;

  assign imm8      = s1_instr.operand_two[7:0];
  assign imm_rot   = {s1_instr.operand_two[11:8], 1'b0};
  assign imm_dbl   = {24'd0, imm8, 24'd0, imm8} >> imm_rot;
  assign rm_dbl    = {rm_rdata, rm_rdata} >> sh_amount;
  assign sh_amount = s1_instr.operand_two[11:7];
  assign sh_kind   = s1_instr.operand_two[6:5];
  assign lsl_bit   = 5'(6'd32 - {1'b0, sh_amount});
  assign rsh_bit   = sh_amount - 5'd1;

  always_comb begin
    op2_val     = '0;
    shift_carry = flags.c;
    if (s1_instr.immediate_form) begin
      op2_val = imm_dbl[31:0];
    end else if (s1_instr.operand_two[4]) begin
      op2_val = '0;
    end else if (sh_amount == 5'd0) begin
      op2_val = rm_rdata;
    end else begin
      case (sh_kind)
        armdp_pkg::SH_LSL: begin
          op2_val     = rm_rdata << sh_amount;
          shift_carry = rm_rdata[lsl_bit];
        end
        armdp_pkg::SH_LSR: begin
          op2_val     = rm_rdata >> sh_amount;
          shift_carry = rm_rdata[rsh_bit];
        end
        armdp_pkg::SH_ASR: begin
          op2_val     = 32'($signed(rm_rdata) >>> sh_amount);
          shift_carry = rm_rdata[rsh_bit];
        end
        default: begin
          op2_val     = rm_dbl[31:0];
          shift_carry = rm_rdata[rsh_bit];
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------------
  // ALU. Subtractions report carry as "no borrow". Tests and compares do not write the
  // destination; an unknown opcode writes zero and leaves the carry alone.
  // ---------------------------------------------------------------------------------
  logic [32:0] sum;
  logic [32:0] diff_nb;
  logic [32:0] diff_bn;
  logic [31:0] alu_res;
  logic        alu_carry;
  logic        alu_write;
  logic        alu_known;

  assign sum     = {1'b0, rn_val} + {1'b0, op2_val};
  assign diff_nb = {1'b0, rn_val} - {1'b0, op2_val};
  assign diff_bn = {1'b0, op2_val} - {1'b0, rn_val};

  always_comb begin
    alu_res   = '0;
    alu_carry = shift_carry;
    alu_write = 1'b1;
    alu_known = 1'b1;
    unique case (s1_instr.opcode)
      armdp_pkg::OP_AND: alu_res = rn_val & op2_val;
      armdp_pkg::OP_EOR: alu_res = rn_val ^ op2_val;
      armdp_pkg::OP_SUB: begin
        alu_res   = diff_nb[31:0];
        alu_carry = !diff_nb[32];
      end
      armdp_pkg::OP_RSB: begin
        alu_res   = diff_bn[31:0];
        alu_carry = !diff_bn[32];
      end
      armdp_pkg::OP_ADD: begin
        alu_res   = sum[31:0];
        alu_carry = sum[32];
      end
      armdp_pkg::OP_TST: begin
        alu_res   = rn_val & op2_val;
        alu_write = 1'b0;
      end
      armdp_pkg::OP_TEQ: begin
        alu_res   = rn_val ^ op2_val;
        alu_write = 1'b0;
      end
      armdp_pkg::OP_CMP: begin
        alu_res   = diff_nb[31:0];
        alu_carry = !diff_nb[32];
        alu_write = 1'b0;
      end
      armdp_pkg::OP_ORR: alu_res = rn_val | op2_val;
      armdp_pkg::OP_MOV: alu_res = op2_val;
      default: begin
        alu_res   = '0;
        alu_known = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------------
  // Writeback and flag update at commit.
  // ---------------------------------------------------------------------------------
  assign mem_we    = s1_advance && alu_write;
  assign mem_waddr = s1_instr.dest_register;
  assign mem_wdata = alu_res;

  always_comb begin
    flags_next = flags;
    if (s1_instr.set_flags) begin
      flags_next.n = alu_res[31];
      flags_next.z = (alu_res == '0);
      if (alu_known) begin
        flags_next.c = alu_carry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (s1_advance) begin
      flags <= flags_next;
    end
  end

  // ---------------------------------------------------------------------------------
  // Output register. It holds a finished result while the next request is read.
  // ---------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_tdata <= {flags_next.c, flags_next.z, flags_next.n, alu_write,
                  s1_instr.dest_register, alu_res};
    end
  end

  // ---------------------------------------------------------------------------------
  // Checks on the pipeline control.
  // ---------------------------------------------------------------------------------
  `ARMDP_ASSERT_SAME(a_no_accept_on_stall, s1_valid && !s1_advance, !s_accept,
    "request accepted while stage 1 is stalled")
  `ARMDP_ASSERT_SAME(a_write_only_on_commit, mem_we, s1_valid && s1_advance,
    "register file written without a committing instruction")
  `ARMDP_ASSERT_NEXT(a_commit_gives_result, s1_advance, m_tvalid,
    "committed instruction left no result in the output register")
  `ARMDP_ASSERT_NEXT(a_flags_hold_without_s, s1_advance && !s1_instr.set_flags,
    $stable(flags), "flags changed by an instruction with S clear")

endmodule

`default_nettype wire
